// ----- src/gravity_orbit_step_top_defines.svh -----
// ----------------------------------------------------------------------------
// Gravity orbit step: assertion macros
// Shared concurrent assertion wrappers, empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef GRAVITY_ORBIT_STEP_TOP_DEFINES_SVH
`define GRAVITY_ORBIT_STEP_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Assertion on an explicit clock and active-low reset.
`define GOS_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Assertion on the block's usual clock and reset.
`define GOS_ASSERT(lbl, prop, msg) \
  `GOS_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define GOS_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define GOS_ASSERT(lbl, prop, msg)
`endif

`endif

// ----- src/gos_pkg.sv -----
// ----------------------------------------------------------------------------
// Gravity orbit step: package
// Fixed constants, codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gos_pkg;

  localparam int POS_SCALE = 64;
  localparam int POS_SHIFT = $clog2(POS_SCALE);
  localparam int ACC_SCALE = 1024;
  localparam int ACC_SHIFT = $clog2(ACC_SCALE);
  localparam int SCREEN_W  = 256;
  localparam int SCREEN_H  = 192;
  localparam int LIM_X     = SCREEN_W * POS_SCALE;
  localparam int LIM_Y     = SCREEN_H * POS_SCALE;

  localparam int TRAIL_W   = 14;
  localparam int ACCUM_W   = 24;
  localparam int R2_W      = 18;
  localparam int DVSR_W    = 17;
  localparam int STEP_W    = 5;
  localparam int SQRT_STEPS = R2_W / 2;
  localparam int DIV_STEPS  = 18;
  localparam logic [R2_W-1:0] SQ_BIT0 = R2_W'(1) << (R2_W - 2);

  localparam logic [3:0] TIME_STEP_RST = 4'd1;
  localparam logic [7:0] START_X_RST   = 8'd128;
  localparam logic [7:0] START_Y_RST   = 8'd96;

  typedef enum logic [1:0] {
    CFG_TIME_STEP = 2'd0,
    CFG_START_X   = 2'd1,
    CFG_START_Y   = 2'd2,
    CFG_NONE      = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FUNC_ATTR   = 2'd0,
    FUNC_TICK   = 2'd1,
    FUNC_LAUNCH = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ATTR, ST_R2, ST_SQRT, ST_MUL, ST_DINIT, ST_DIV, ST_ACC,
    ST_INT1, ST_INT2, ST_INT3, ST_EMIT
  } state_e;

  typedef struct packed {
    logic attr_wr;
    logic launch;
    logic tick_start;
    logic load;
    logic sq_init;
    logic sq_step;
    logic mul;
    logic div_init;
    logic div_step;
    logic acc;
    logic int1;
    logic int2;
    logic int3;
  } dp_cmd_t;

  typedef struct packed {
    logic mu_zero;
    logic div_zero;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- src/gos_ctrl.sv -----
// ----------------------------------------------------------------------------
// Gravity orbit step: controller
// Sequences the attractor loop, integration and trail emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "gravity_orbit_step_top_defines.svh"

module gos_ctrl #(
  parameter int ATTRACTORS  = 4,
  parameter int TRAIL_DEPTH = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic [1:0]          func_i,
  output      logic                in_stall_o,
  input  wire logic                out_stall_i,
  output      logic                out_valid_o,
  output      logic                last_o,
  input  wire gos_pkg::dp_sts_t    sts_i,
  output      gos_pkg::dp_cmd_t    cmd_o,
  output      logic [((ATTRACTORS > 1) ? $clog2(ATTRACTORS) : 1)-1:0]   attr_idx_o,
  output      logic [((TRAIL_DEPTH > 1) ? $clog2(TRAIL_DEPTH) : 1)-1:0] trail_idx_o
);

  localparam int AW = (ATTRACTORS > 1) ? $clog2(ATTRACTORS) : 1;
  localparam int TW = (TRAIL_DEPTH > 1) ? $clog2(TRAIL_DEPTH) : 1;

  gos_pkg::state_e state_q, state_d;
  logic [AW-1:0] aidx_q, aidx_d;
  logic [TW-1:0] tidx_q, tidx_d;
  logic [gos_pkg::STEP_W-1:0] step_q, step_d;
  logic attr_last, trail_last;

  assign attr_last  = (aidx_q == AW'(ATTRACTORS - 1));
  assign trail_last = (tidx_q == TW'(TRAIL_DEPTH - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gos_pkg::ST_IDLE;
      aidx_q  <= '0;
      tidx_q  <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      aidx_q  <= aidx_d;
      tidx_q  <= tidx_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d = state_q;
    aidx_d  = aidx_q;
    tidx_d  = tidx_q;
    step_d  = step_q;
    cmd_o   = '0;
    unique case (state_q)
      gos_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          unique case (gos_pkg::func_e'(func_i))
            gos_pkg::FUNC_ATTR:   cmd_o.attr_wr = 1'b1;
            gos_pkg::FUNC_LAUNCH: cmd_o.launch = 1'b1;
            gos_pkg::FUNC_TICK: begin
              cmd_o.tick_start = 1'b1;
              aidx_d  = '0;
              state_d = gos_pkg::ST_ATTR;
            end
            default: ;
          endcase
        end
      end
      gos_pkg::ST_ATTR: begin
        cmd_o.load = 1'b1;
        if (!sts_i.mu_zero) begin
          state_d = gos_pkg::ST_R2;
        end else if (attr_last) begin
          state_d = gos_pkg::ST_INT1;
        end else begin
          aidx_d = AW'(aidx_q + 1'b1);
        end
      end
      gos_pkg::ST_R2: begin
        cmd_o.sq_init = 1'b1;
        step_d  = '0;
        state_d = gos_pkg::ST_SQRT;
      end
      gos_pkg::ST_SQRT: begin
        cmd_o.sq_step = 1'b1;
        step_d = gos_pkg::STEP_W'(step_q + 1'b1);
        if (step_q == gos_pkg::STEP_W'(gos_pkg::SQRT_STEPS - 1)) begin
          state_d = gos_pkg::ST_MUL;
        end
      end
      gos_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = gos_pkg::ST_DINIT;
      end
      gos_pkg::ST_DINIT: begin
        if (!sts_i.div_zero) begin
          cmd_o.div_init = 1'b1;
          step_d  = '0;
          state_d = gos_pkg::ST_DIV;
        end else if (attr_last) begin
          state_d = gos_pkg::ST_INT1;
        end else begin
          aidx_d  = AW'(aidx_q + 1'b1);
          state_d = gos_pkg::ST_ATTR;
        end
      end
      gos_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d = gos_pkg::STEP_W'(step_q + 1'b1);
        if (step_q == gos_pkg::STEP_W'(gos_pkg::DIV_STEPS - 1)) begin
          state_d = gos_pkg::ST_ACC;
        end
      end
      gos_pkg::ST_ACC: begin
        cmd_o.acc = 1'b1;
        if (attr_last) begin
          state_d = gos_pkg::ST_INT1;
        end else begin
          aidx_d  = AW'(aidx_q + 1'b1);
          state_d = gos_pkg::ST_ATTR;
        end
      end
      gos_pkg::ST_INT1: begin
        cmd_o.int1 = 1'b1;
        state_d = gos_pkg::ST_INT2;
      end
      gos_pkg::ST_INT2: begin
        cmd_o.int2 = 1'b1;
        state_d = gos_pkg::ST_INT3;
      end
      gos_pkg::ST_INT3: begin
        cmd_o.int3 = 1'b1;
        tidx_d  = '0;
        state_d = gos_pkg::ST_EMIT;
      end
      gos_pkg::ST_EMIT: begin
        if (!out_stall_i) begin
          if (trail_last) begin
            state_d = gos_pkg::ST_IDLE;
          end else begin
            tidx_d = TW'(tidx_q + 1'b1);
          end
        end
      end
      default: state_d = gos_pkg::ST_IDLE;
    endcase
  end

  assign in_stall_o  = (state_q != gos_pkg::ST_IDLE);
  assign out_valid_o = (state_q == gos_pkg::ST_EMIT);
  assign last_o      = trail_last;
  assign attr_idx_o  = aidx_q;
  assign trail_idx_o = tidx_q;

  `GOS_ASSERT(a_emit_ends, (state_q == gos_pkg::ST_EMIT && !out_stall_i && trail_last) |=> (state_q == gos_pkg::ST_IDLE), "emission did not end after the oldest entry")
  `GOS_ASSERT(a_emit_stays, (state_q == gos_pkg::ST_EMIT) |=> (state_q == gos_pkg::ST_EMIT || state_q == gos_pkg::ST_IDLE), "emission left early")
  `GOS_ASSERT(a_div_exit, (state_q == gos_pkg::ST_DIV) |=> (state_q == gos_pkg::ST_DIV || state_q == gos_pkg::ST_ACC), "divide did not finish into accumulate")

endmodule

`default_nettype wire

// ----- src/gos_dp.sv -----
// ----------------------------------------------------------------------------
// Gravity orbit step: datapath
// Attractor table, trail, velocity, iterative square root and divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gos_dp #(
  parameter int ATTRACTORS  = 4,
  parameter int TRAIL_DEPTH = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire gos_pkg::dp_cmd_t    cmd_i,
  output      gos_pkg::dp_sts_t    sts_o,
  input  wire logic [((ATTRACTORS > 1) ? $clog2(ATTRACTORS) : 1)-1:0]   attr_idx_i,
  input  wire logic [((TRAIL_DEPTH > 1) ? $clog2(TRAIL_DEPTH) : 1)-1:0] trail_idx_i,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [7:0]          cfg_data_i,
  input  wire logic [3:0]          attractor_index_i,
  input  wire logic [7:0]          attractor_x_i,
  input  wire logic [7:0]          attractor_y_i,
  input  wire logic [7:0]          attractor_mu_i,
  input  wire logic signed [15:0]  launch_vel_x_i,
  input  wire logic signed [15:0]  launch_vel_y_i,
  output      logic [13:0]         trail_x_o,
  output      logic [13:0]         trail_y_o,
  output      logic signed [15:0]  vel_x_o,
  output      logic signed [15:0]  vel_y_o
);

  localparam int AW = (ATTRACTORS > 1) ? $clog2(ATTRACTORS) : 1;
  localparam int TRW = gos_pkg::TRAIL_W;
  localparam int RW = gos_pkg::R2_W;
  localparam int DW = gos_pkg::DVSR_W;
  localparam int QW = gos_pkg::DIV_STEPS;
  localparam logic signed [31:0] LIM_X = 32'(gos_pkg::LIM_X);
  localparam logic signed [31:0] LIM_Y = 32'(gos_pkg::LIM_Y);

  // Truncating signed shift: rounds toward zero like a C division.
  function automatic logic signed [31:0] trunc_shr(input logic signed [31:0] v,
                                                   input logic [4:0] sh);
    logic signed [31:0] bias;
    bias = (v < 0) ? ((32'sd1 <<< sh) - 32'sd1) : 32'sd0;
    return (v + bias) >>> sh;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'sd32767) r = 16'sh7fff;
    else if (v < -20'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  // One restoring divide step: returns {remainder, quotient}.
  function automatic logic [2*QW-1:0] div_step(input logic [QW-1:0] rem,
                                               input logic [QW-1:0] quo,
                                               input logic [DW-1:0] d);
    logic [QW-1:0] sh;
    logic [2*QW-1:0] r;
    sh = {rem[QW-2:0], quo[QW-1]};
    if (sh >= QW'(d)) r = {sh - QW'(d), quo[QW-2:0], 1'b1};
    else r = {sh, quo[QW-2:0], 1'b0};
    return r;
  endfunction

  function automatic logic [TRW-1:0] wrap(input logic signed [31:0] v,
                                          input logic signed [31:0] lim);
    logic [TRW-1:0] r;
    if (v < 0) r = TRW'(lim - 32'sd1);
    else if (v >= lim) r = '0;
    else r = v[TRW-1:0];
    return r;
  endfunction

  // Architectural state.
  logic [3:0] time_step_q;
  logic [7:0] start_x_q, start_y_q;
  logic [7:0] att_x_q [ATTRACTORS];
  logic [7:0] att_y_q [ATTRACTORS];
  logic [7:0] att_mu_q [ATTRACTORS];
  logic [TRW-1:0] trail_x_q [TRAIL_DEPTH];
  logic [TRW-1:0] trail_y_q [TRAIL_DEPTH];
  logic signed [15:0] vel_x_q, vel_y_q;

  // Working registers.
  logic signed [9:0] dx_q, dy_q;
  logic [7:0] mu_q;
  logic [RW-1:0] r2_q, sq_rem_q, sq_res_q, sq_bit_q;
  logic [DW-1:0] dvsr_q;
  logic signed [18:0] num_x_q, num_y_q;
  logic [QW-1:0] qx_q, qy_q, rx_q, ry_q;
  logic neg_x_q, neg_y_q;
  logic signed [gos_pkg::ACCUM_W-1:0] acc_x_q, acc_y_q;
  logic signed [27:0] axdt_x_q, axdt_y_q;
  logic signed [19:0] veldt_x_q, veldt_y_q;
  logic signed [31:0] axdt2_x_q, axdt2_y_q;

  logic [7:0] px_pix, py_pix;
  logic signed [9:0] dx_d, dy_d;
  logic signed [19:0] sqx, sqy, r2_sum;
  logic [RW-1:0] sq_try;
  logic [26:0] prod;
  logic [2*QW-1:0] stx, sty;
  logic signed [18:0] qsx, qsy;
  logic signed [4:0] dt_s;
  logic signed [31:0] npx, npy;
  logic attr_ok;

  assign px_pix = 8'(trail_x_q[0] >> gos_pkg::POS_SHIFT);
  assign py_pix = 8'(trail_y_q[0] >> gos_pkg::POS_SHIFT);
  assign dx_d   = $signed({2'b00, att_x_q[attr_idx_i]}) - $signed({2'b00, px_pix});
  assign dy_d   = $signed({2'b00, att_y_q[attr_idx_i]}) - $signed({2'b00, py_pix});
  assign sqx    = 20'(dx_q) * 20'(dx_q);
  assign sqy    = 20'(dy_q) * 20'(dy_q);
  assign r2_sum = sqx + sqy;
  assign sq_try = sq_res_q + sq_bit_q;
  assign prod   = 27'(r2_q) * 27'(sq_res_q[8:0]);
  assign stx    = div_step(rx_q, qx_q, dvsr_q);
  assign sty    = div_step(ry_q, qy_q, dvsr_q);
  assign qsx    = neg_x_q ? -$signed({1'b0, qx_q}) : $signed({1'b0, qx_q});
  assign qsy    = neg_y_q ? -$signed({1'b0, qy_q}) : $signed({1'b0, qy_q});
  assign dt_s   = $signed({1'b0, time_step_q});
  assign npx    = 32'($signed({1'b0, trail_x_q[0]})) + 32'(veldt_x_q)
                + trunc_shr(axdt2_x_q, 5'(gos_pkg::ACC_SHIFT + 1));
  assign npy    = 32'($signed({1'b0, trail_y_q[0]})) + 32'(veldt_y_q)
                + trunc_shr(axdt2_y_q, 5'(gos_pkg::ACC_SHIFT + 1));
  assign attr_ok = ({1'b0, attractor_index_i} < 5'(ATTRACTORS));

  assign sts_o.mu_zero  = (att_mu_q[attr_idx_i] == 8'd0);
  assign sts_o.div_zero = (dvsr_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q <= gos_pkg::TIME_STEP_RST;
      start_x_q   <= gos_pkg::START_X_RST;
      start_y_q   <= gos_pkg::START_Y_RST;
      for (int i = 0; i < ATTRACTORS; i++) begin
        att_x_q[i]  <= '0;
        att_y_q[i]  <= '0;
        att_mu_q[i] <= '0;
      end
      for (int i = 0; i < TRAIL_DEPTH; i++) begin
        trail_x_q[i] <= '0;
        trail_y_q[i] <= '0;
      end
      vel_x_q <= '0;
      vel_y_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (gos_pkg::cfg_idx_e'(cfg_index_i))
          gos_pkg::CFG_TIME_STEP: time_step_q <= cfg_data_i[3:0];
          gos_pkg::CFG_START_X:   start_x_q <= cfg_data_i;
          gos_pkg::CFG_START_Y:   start_y_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.attr_wr && attr_ok) begin
        att_x_q[attractor_index_i[AW-1:0]]  <= attractor_x_i;
        att_y_q[attractor_index_i[AW-1:0]]  <= attractor_y_i;
        att_mu_q[attractor_index_i[AW-1:0]] <= attractor_mu_i;
      end
      if (cmd_i.launch) begin
        for (int i = 0; i < TRAIL_DEPTH; i++) begin
          trail_x_q[i] <= TRW'(start_x_q) << gos_pkg::POS_SHIFT;
          trail_y_q[i] <= TRW'(start_y_q) << gos_pkg::POS_SHIFT;
        end
        vel_x_q <= launch_vel_x_i;
        vel_y_q <= launch_vel_y_i;
      end
      if (cmd_i.int2) begin
        vel_x_q <= sat16(20'(vel_x_q)
                   + 20'(trunc_shr(32'(axdt_x_q), 5'(gos_pkg::ACC_SHIFT))));
        vel_y_q <= sat16(20'(vel_y_q)
                   + 20'(trunc_shr(32'(axdt_y_q), 5'(gos_pkg::ACC_SHIFT))));
      end
      if (cmd_i.int3) begin
        for (int i = TRAIL_DEPTH - 1; i > 0; i--) begin
          trail_x_q[i] <= trail_x_q[i-1];
          trail_y_q[i] <= trail_y_q[i-1];
        end
        trail_x_q[0] <= wrap(npx, LIM_X);
        trail_y_q[0] <= wrap(npy, LIM_Y);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
      mu_q <= att_mu_q[attr_idx_i];
    end
    if (cmd_i.sq_init) begin
      r2_q     <= r2_sum[RW-1:0];
      sq_rem_q <= r2_sum[RW-1:0];
      sq_res_q <= '0;
      sq_bit_q <= gos_pkg::SQ_BIT0;
    end
    if (cmd_i.sq_step) begin
      if (sq_rem_q >= sq_try) begin
        sq_rem_q <= sq_rem_q - sq_try;
        sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
      end else begin
        sq_res_q <= sq_res_q >> 1;
      end
      sq_bit_q <= sq_bit_q >> 2;
    end
    if (cmd_i.mul) begin
      dvsr_q  <= DW'(prod >> gos_pkg::ACC_SHIFT);
      num_x_q <= 19'($signed({1'b0, mu_q})) * 19'(dx_q);
      num_y_q <= 19'($signed({1'b0, mu_q})) * 19'(dy_q);
    end
    if (cmd_i.div_init) begin
      qx_q    <= QW'(num_x_q[18] ? -num_x_q : num_x_q);
      qy_q    <= QW'(num_y_q[18] ? -num_y_q : num_y_q);
      rx_q    <= '0;
      ry_q    <= '0;
      neg_x_q <= num_x_q[18];
      neg_y_q <= num_y_q[18];
    end
    if (cmd_i.div_step) begin
      {rx_q, qx_q} <= stx;
      {ry_q, qy_q} <= sty;
    end
    if (cmd_i.tick_start) begin
      acc_x_q <= '0;
      acc_y_q <= '0;
    end
    if (cmd_i.acc) begin
      acc_x_q <= acc_x_q + gos_pkg::ACCUM_W'(qsx);
      acc_y_q <= acc_y_q + gos_pkg::ACCUM_W'(qsy);
    end
    if (cmd_i.int1) begin
      axdt_x_q  <= 28'(acc_x_q) * 28'(dt_s);
      axdt_y_q  <= 28'(acc_y_q) * 28'(dt_s);
      veldt_x_q <= 20'(vel_x_q) * 20'(dt_s);
      veldt_y_q <= 20'(vel_y_q) * 20'(dt_s);
    end
    if (cmd_i.int2) begin
      axdt2_x_q <= 32'(axdt_x_q) * 32'(dt_s);
      axdt2_y_q <= 32'(axdt_y_q) * 32'(dt_s);
    end
  end

  assign trail_x_o = trail_x_q[trail_idx_i];
  assign trail_y_o = trail_y_q[trail_idx_i];
  assign vel_x_o   = vel_x_q;
  assign vel_y_o   = vel_y_q;

endmodule

`default_nettype wire

// ----- src/gravity_orbit_step_top.sv -----
// ----------------------------------------------------------------------------
// Gravity orbit step: top level
// One body pulled by a small table of point attractors, Euler integrated.
// ----------------------------------------------------------------------------
// Attractor writes and launches are applied in idle; other codes are dropped.
// A tick loads each attractor; an enabled one runs square root, multiply,
// divide and accumulate, the last two skipped for a zero divisor. INT1 to INT3
// then integrate; TRAIL_DEPTH items go out, one a cycle while not stalled.
// The root takes 9 steps, the divider 18; input stalls till the trail is out.
// Reset clears trail, velocity and attractor table at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module gravity_orbit_step_top #(
  parameter int ATTRACTORS  = 4,
  parameter int TRAIL_DEPTH = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Configuration write port.
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [7:0]         cfg_data_i,
  // Input item channel.
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic [1:0]         func_i,
  input  wire logic [3:0]         attractor_index_i,
  input  wire logic [7:0]         attractor_x_i,
  input  wire logic [7:0]         attractor_y_i,
  input  wire logic [7:0]         attractor_mu_i,
  input  wire logic signed [15:0] launch_vel_x_i,
  input  wire logic signed [15:0] launch_vel_y_i,
  // Result item channel.
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic [13:0]        trail_x_o,
  output      logic [13:0]        trail_y_o,
  output      logic signed [15:0] vel_x_o,
  output      logic signed [15:0] vel_y_o,
  output      logic               last_o
);

  localparam int AW = (ATTRACTORS > 1) ? $clog2(ATTRACTORS) : 1;
  localparam int TW = (TRAIL_DEPTH > 1) ? $clog2(TRAIL_DEPTH) : 1;

  gos_pkg::dp_cmd_t cmd;
  gos_pkg::dp_sts_t sts;
  logic [AW-1:0] attr_idx;
  logic [TW-1:0] trail_idx;

  // The controller walks the attractor table, runs the iterative square root
  // and divider, then integration states INT1 to INT3, then streams the trail.
  gos_ctrl #(
    .ATTRACTORS (ATTRACTORS),
    .TRAIL_DEPTH(TRAIL_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .in_stall_o (in_stall_o),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .last_o     (last_o),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .attr_idx_o (attr_idx),
    .trail_idx_o(trail_idx)
  );

  // The datapath holds all architectural state; trail fields are read at the
  // controller's index, and all result fields stay stable while stalled.
  gos_dp #(
    .ATTRACTORS (ATTRACTORS),
    .TRAIL_DEPTH(TRAIL_DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .attr_idx_i       (attr_idx),
    .trail_idx_i      (trail_idx),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .attractor_index_i(attractor_index_i),
    .attractor_x_i    (attractor_x_i),
    .attractor_y_i    (attractor_y_i),
    .attractor_mu_i   (attractor_mu_i),
    .launch_vel_x_i   (launch_vel_x_i),
    .launch_vel_y_i   (launch_vel_y_i),
    .trail_x_o        (trail_x_o),
    .trail_y_o        (trail_y_o),
    .vel_x_o          (vel_x_o),
    .vel_y_o          (vel_y_o)
  );

endmodule

`default_nettype wire

// ----- tb/gravity_orbit_step_checker.sv -----
// ----------------------------------------------------------------------------
// Gravity orbit step: result checker
// Watches the register port and both item channels and predicts the trail
// items of every tick. Each result item is compared with the oldest
// prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gravity_orbit_step_checker #(
  parameter int ATTRACTORS  = 4,
  parameter int TRAIL_DEPTH = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [1:0]         func_i,
  input  logic [3:0]         attractor_index_i,
  input  logic [7:0]         attractor_x_i,
  input  logic [7:0]         attractor_y_i,
  input  logic [7:0]         attractor_mu_i,
  input  logic signed [15:0] launch_vel_x_i,
  input  logic signed [15:0] launch_vel_y_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [13:0]        trail_x_i,
  input  logic [13:0]        trail_y_i,
  input  logic signed [15:0] vel_x_i,
  input  logic signed [15:0] vel_y_i,
  input  logic               last_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 results_seen_o
);

  typedef struct packed {
    logic [13:0]        trail_x;
    logic [13:0]        trail_y;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic               last;
  } trail_item_t;

  trail_item_t trail_expected[$];

  logic [3:0] dt_q;
  logic [7:0] start_x_q, start_y_q;
  longint     body_x[TRAIL_DEPTH];
  longint     body_y[TRAIL_DEPTH];
  longint     speed_x, speed_y;
  longint     well_x[ATTRACTORS];
  longint     well_y[ATTRACTORS];
  longint     well_mu[ATTRACTORS];

  initial begin
    fail_count_o   = 0;
    results_seen_o = 0;
  end

  assign pending_o = trail_expected.size();

  function automatic longint root_floor(longint unsigned n);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n  -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint wrap_edge(longint v, longint lim);
    if (v < 0) return lim - 1;
    if (v >= lim) return 0;
    return v;
  endfunction

  task automatic advance_body();
    longint dt, px, py, acc_x, acc_y, dx, dy, r2, dvsr, nx, ny;
    trail_item_t it;
    dt    = longint'(dt_q);
    px    = body_x[0];
    py    = body_y[0];
    acc_x = 0;
    acc_y = 0;
    for (int i = 0; i < ATTRACTORS; i++) begin
      if (well_mu[i] != 0) begin
        dx   = well_x[i] - px / gos_pkg::POS_SCALE;
        dy   = well_y[i] - py / gos_pkg::POS_SCALE;
        r2   = dx * dx + dy * dy;
        dvsr = r2 * root_floor(r2) / gos_pkg::ACC_SCALE;
        // A divisor that truncates to zero gives no pull; skip the attractor.
        if (dvsr != 0) begin
          acc_x += (well_mu[i] * dx) / dvsr;
          acc_y += (well_mu[i] * dy) / dvsr;
        end
      end
    end
    nx = px + speed_x * dt + (acc_x * dt * dt) / (2 * longint'(gos_pkg::ACC_SCALE));
    ny = py + speed_y * dt + (acc_y * dt * dt) / (2 * longint'(gos_pkg::ACC_SCALE));
    for (int i = TRAIL_DEPTH - 1; i > 0; i--) begin
      body_x[i] = body_x[i-1];
      body_y[i] = body_y[i-1];
    end
    body_x[0] = wrap_edge(nx, longint'(gos_pkg::LIM_X));
    body_y[0] = wrap_edge(ny, longint'(gos_pkg::LIM_Y));
    speed_x   = clamp16(speed_x + (acc_x * dt) / gos_pkg::ACC_SCALE);
    speed_y   = clamp16(speed_y + (acc_y * dt) / gos_pkg::ACC_SCALE);
    for (int i = 0; i < TRAIL_DEPTH; i++) begin
      it.trail_x = body_x[i][13:0];
      it.trail_y = body_y[i][13:0];
      it.vel_x   = speed_x[15:0];
      it.vel_y   = speed_y[15:0];
      it.last    = (i == TRAIL_DEPTH - 1);
      trail_expected.push_back(it);
    end
  endtask

  task automatic report(string what, longint got, longint want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q      = gos_pkg::TIME_STEP_RST;
      start_x_q = gos_pkg::START_X_RST;
      start_y_q = gos_pkg::START_Y_RST;
      speed_x   = 0;
      speed_y   = 0;
      for (int i = 0; i < TRAIL_DEPTH; i++) begin
        body_x[i] = 0;
        body_y[i] = 0;
      end
      for (int i = 0; i < ATTRACTORS; i++) begin
        well_x[i]  = 0;
        well_y[i]  = 0;
        well_mu[i] = 0;
      end
      trail_expected.delete();
    end else begin
      if (cfg_we_i) begin
        case (gos_pkg::cfg_idx_e'(cfg_index_i))
          gos_pkg::CFG_TIME_STEP: dt_q = cfg_data_i[3:0];
          gos_pkg::CFG_START_X:   start_x_q = cfg_data_i;
          gos_pkg::CFG_START_Y:   start_y_q = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        results_seen_o++;
        if (trail_expected.size() == 0) begin
          report("unexpected result item, trail_x", trail_x_i, 0);
        end else begin
          trail_item_t w;
          w = trail_expected.pop_front();
          if (trail_x_i !== w.trail_x) report("trail_x", trail_x_i, w.trail_x);
          if (trail_y_i !== w.trail_y) report("trail_y", trail_y_i, w.trail_y);
          if (vel_x_i !== w.vel_x) report("vel_x", vel_x_i, w.vel_x);
          if (vel_y_i !== w.vel_y) report("vel_y", vel_y_i, w.vel_y);
          if (last_i !== w.last) report("last", last_i, w.last);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        case (gos_pkg::func_e'(func_i))
          gos_pkg::FUNC_ATTR: begin
            if (attractor_index_i < ATTRACTORS) begin
              well_x[attractor_index_i]  = attractor_x_i;
              well_y[attractor_index_i]  = attractor_y_i;
              well_mu[attractor_index_i] = attractor_mu_i;
            end
          end
          gos_pkg::FUNC_LAUNCH: begin
            for (int i = 0; i < TRAIL_DEPTH; i++) begin
              body_x[i] = longint'(start_x_q) * gos_pkg::POS_SCALE;
              body_y[i] = longint'(start_y_q) * gos_pkg::POS_SCALE;
            end
            speed_x = launch_vel_x_i;
            speed_y = launch_vel_y_i;
          end
          gos_pkg::FUNC_TICK: advance_body();
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- tb/tb_gravity_orbit_step_top.sv -----
// ----------------------------------------------------------------------------
// Gravity orbit step: testbench top
// Drives register writes and input items into the block under random idling
// and stalling, and gives the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_gravity_orbit_step_top;

  // This limit covers, many times over, the slowest tick: all attractors divide
  // and eight trail items may each sit behind a stalled receiver.
  localparam int CYCLE_LIMIT = 600000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_index_i = '0;
  logic [7:0]         cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         func_i = '0;
  logic [3:0]         attractor_index_i = '0;
  logic [7:0]         attractor_x_i = '0;
  logic [7:0]         attractor_y_i = '0;
  logic [7:0]         attractor_mu_i = '0;
  logic signed [15:0] launch_vel_x_i = '0;
  logic signed [15:0] launch_vel_y_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [13:0]        trail_x_o;
  logic [13:0]        trail_y_o;
  logic signed [15:0] vel_x_o;
  logic signed [15:0] vel_y_o;
  logic               last_o;

  int fail_count, pending, results_seen;
  int idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int cycles = 0;

  gravity_orbit_step_top dut (.*);

  gravity_orbit_step_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .func_i, .attractor_index_i,
    .attractor_x_i, .attractor_y_i, .attractor_mu_i,
    .launch_vel_x_i, .launch_vel_y_i,
    .out_valid_i(out_valid_o), .out_stall_i, .trail_x_i(trail_x_o),
    .trail_y_i(trail_y_o), .vel_x_i(vel_x_o), .vel_y_i(vel_y_o), .last_i(last_o),
    .fail_count_o(fail_count), .pending_o(pending), .results_seen_o(results_seen)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // The receiver stalls at random with the probability of the current phase.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: a hung block ends the run as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("gravity_orbit_step_top test failed");
      $finish;
    end
  end

  // Sends one item. Idle cycles come first, and valid stays high between
  // back-to-back items, so it is never lowered and raised in one step.
  task automatic send_item(gos_pkg::func_e f, logic [3:0] idx, logic [7:0] ax,
                           logic [7:0] ay, logic [7:0] mu, logic [15:0] vx,
                           logic [15:0] vy);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    func_i            <= f;
    attractor_index_i <= idx;
    attractor_x_i     <= ax;
    attractor_y_i     <= ay;
    attractor_mu_i    <= mu;
    launch_vel_x_i    <= vx;
    launch_vel_y_i    <= vy;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // Waits until every predicted trail item has come back, then lets the
  // block settle, since attractor writes and launches produce no result.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(gos_pkg::cfg_idx_e idx, logic [7:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_tick();
    send_item(gos_pkg::FUNC_TICK, 4'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // Random traffic. Most items are ticks, so the body keeps moving, with
  // attractor rewrites, relaunches and an occasional unused code mixed in.
  task automatic random_traffic(int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_tick();
      end else if (pick < 78) begin
        send_item(gos_pkg::FUNC_ATTR, 4'($urandom_range(7)), 8'($urandom),
                  8'($urandom), ($urandom_range(4) == 0) ? 8'd0 : 8'($urandom),
                  16'($urandom), 16'($urandom));
      end else if (pick < 95) begin
        send_item(gos_pkg::FUNC_LAUNCH, 4'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom),
                  ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(600) - 300),
                  ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(600) - 300));
      end else begin
        send_item(gos_pkg::FUNC_NONE, 4'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 16'($urandom), 16'($urandom));
        n--;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: no idling. The first tick runs from the reset state.
    send_tick();
    send_item(gos_pkg::FUNC_ATTR, 4'd0, 8'd200, 8'd40, 8'd255, 16'd0, 16'd0);
    // An attractor on the launch point gives a zero divisor.
    send_item(gos_pkg::FUNC_ATTR, 4'd1, 8'd128, 8'd96, 8'd1, 16'd0, 16'd0);
    // A zero strength entry is disabled; an index past the table is dropped.
    send_item(gos_pkg::FUNC_ATTR, 4'd2, 8'd255, 8'd255, 8'd0, 16'd0, 16'd0);
    send_item(gos_pkg::FUNC_ATTR, 4'd15, 8'd10, 8'd10, 8'd200, 16'd0, 16'd0);
    send_item(gos_pkg::FUNC_LAUNCH, 4'd0, 8'd0, 8'd0, 8'd0, 16'sd0, 16'sd0);
    send_tick();
    send_tick();
    // The unused code does nothing.
    send_item(gos_pkg::FUNC_NONE, 4'hf, 8'hff, 8'hff, 8'hff, 16'hffff, 16'hffff);
    // Full-scale launch velocities push velocity into saturation and the
    // body across the screen edges.
    send_item(gos_pkg::FUNC_LAUNCH, 4'd0, 8'd0, 8'd0, 8'd0, 16'sh7fff, -16'sh8000);
    send_tick();
    send_tick();
    send_item(gos_pkg::FUNC_LAUNCH, 4'd0, 8'd0, 8'd0, 8'd0, -16'sh8000, 16'sh7fff);
    send_tick();
    send_item(gos_pkg::FUNC_ATTR, 4'd3, 8'd0, 8'd0, 8'd255, 16'd0, 16'd0);
    send_tick();
    drain();

    // Largest time step and a start point off the screen.
    write_reg(gos_pkg::CFG_TIME_STEP, 8'd15);
    write_reg(gos_pkg::CFG_START_X, 8'd255);
    write_reg(gos_pkg::CFG_START_Y, 8'd255);
    write_reg(gos_pkg::CFG_NONE, 8'hff);
    send_item(gos_pkg::FUNC_LAUNCH, 4'd0, 8'd0, 8'd0, 8'd0, 16'sd100, -16'sd100);
    send_tick();
    send_tick();
    drain();
    // A zero time step leaves the body in place.
    write_reg(gos_pkg::CFG_TIME_STEP, 8'd0);
    write_reg(gos_pkg::CFG_START_X, 8'd0);
    write_reg(gos_pkg::CFG_START_Y, 8'd0);
    send_item(gos_pkg::FUNC_LAUNCH, 4'd0, 8'd0, 8'd0, 8'd0, 16'sd500, 16'sd500);
    send_tick();
    send_tick();
    drain();

    // Random part in four phases of idling, each after a fresh setting.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 55; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 55; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      write_reg(gos_pkg::CFG_TIME_STEP, (ph == 0) ? 8'd1 : 8'($urandom_range(15)));
      write_reg(gos_pkg::CFG_START_X, 8'($urandom));
      write_reg(gos_pkg::CFG_START_Y, 8'($urandom));
      random_traffic(19);
      // The sender holds off until the block has returned everything.
      drain();
      random_traffic(19);
      drain();
    end

    idle_pct  = 0;
    stall_pct = 0;
    $display("covered %0d input items and %0d trail results over four idling phases",
             items_sent, results_seen);
    $display("time steps 0, 1, 15 and random, start points at both extremes");
    if (fail_count == 0) begin
      $display("gravity_orbit_step_top test passed");
    end else begin
      $display("gravity_orbit_step_top test failed");
    end
    $finish;
  end

endmodule
